>>> sv/skdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skdb_pkg: shared types and constants of the shift-chain key debounce scanner
// Field widths, register codes, reset values and the key table row layout.
// ----------------------------------------------------------------------------
package skdb_pkg;

	localparam int KEYS_PER_BYTE = 8;
	localparam int WORD_W        = 8;               // debounce word: flag + count
	localparam int COUNT_W       = 7;
	localparam int POS_W         = 5;               // frame position, bound by 5-bit counts
	localparam int IDX_W         = 4;               // reported byte index
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 7;
	// table row: key state byte in [7:0], debounce word of key i at [8+8i +: 8]
	localparam int ROW_W         = KEYS_PER_BYTE + KEYS_PER_BYTE * WORD_W;

	localparam logic [POS_W-1:0]   IN_BYTES_RST  = 5'd16;
	localparam logic [POS_W-1:0]   OUT_BYTES_RST = 5'd0;
	localparam logic [COUNT_W-1:0] TICKS_RST     = 7'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_BYTES  = 2'd0,
		CFG_OUT_BYTES = 2'd1,
		CFG_TICKS     = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_BYTE  = 1'b1
	} op_t;

	typedef struct packed {
		logic [7:0]       key_byte;
		logic [IDX_W-1:0] byte_index;
		logic             last;
	} rslt_t;

endpackage
`default_nettype wire

>>> sv/skdb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skdb_if: valid/ready channels of the scanner
// key_in_if carries chain bytes and frame starts, key_out_if debounced bytes.
// ----------------------------------------------------------------------------
interface key_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface key_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;
	logic [3:0] byte_index;
	logic       last;

	modport source (output valid, output key_byte, output byte_index, output last,
		input ready);
	modport sink   (input valid, input key_byte, input byte_index, input last,
		output ready);
endinterface
`default_nettype wire

>>> sv/skdb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skdb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module skdb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> sv/shift_chain_key_debounce_scanner_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shift_chain_key_debounce_scanner_unit: key scanner with counter debounce
// Frames chain bytes, debounces 8 keys per byte against a row in RAM and
// returns the held-key byte for every real input position of the frame.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  key_in    in   valid/ready        op, rx_byte
//  key_out   out  valid/ready        key_byte, byte_index, last
//  cfg       in   cfg_we (no stall)  cfg_idx, cfg_data
//
// One byte per cycle sustained while key_out is not stalled. Accept issues the
// row read, the next cycle runs the 8 debounce lanes, writes the row back
// and queues the result. Back-to-back bytes to one row are forwarded.
// key_out is a 2-entry queue; key_in stalls only when queued plus in-flight
// results reach two and no result transfer drains one in the same cycle.
// No clearing pass: per-row valid bits clear at reset.
// ----------------------------------------------------------------------------
module shift_chain_key_debounce_scanner_unit #(
	parameter int MAX_IN_BYTES  = 16,
	parameter int MAX_OUT_BYTES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	key_in_if.sink                             key_in,
	key_out_if.source                          key_out,
	input  wire logic                          cfg_we,
	input  wire logic [skdb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [skdb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import skdb_pkg::*;

	localparam int AW = (MAX_IN_BYTES > 1) ? $clog2(MAX_IN_BYTES) : 1;
	localparam logic [POS_W-1:0] IN_CAP  = POS_W'((MAX_IN_BYTES > 31) ? 31 : MAX_IN_BYTES);
	localparam logic [POS_W-1:0] OUT_CAP = POS_W'((MAX_OUT_BYTES > 31) ? 31 : MAX_OUT_BYTES);

	// configuration
	logic [POS_W-1:0]   in_bytes_q, out_bytes_q;
	logic [COUNT_W-1:0] ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bytes_q  <= IN_BYTES_RST;
			out_bytes_q <= OUT_BYTES_RST;
			ticks_q     <= TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_IN_BYTES:  in_bytes_q  <= cfg_data[POS_W-1:0];
				CFG_OUT_BYTES: out_bytes_q <= cfg_data[POS_W-1:0];
				CFG_TICKS:     ticks_q     <= cfg_data;
				default:       ;
			endcase
		end
	end

	// frame geometry: length = max(in, out), leading (len - in) are padding
	logic [POS_W-1:0] nin, nout, flen, pad;
	assign nin  = (in_bytes_q  > IN_CAP)  ? IN_CAP  : in_bytes_q;
	assign nout = (out_bytes_q > OUT_CAP) ? OUT_CAP : out_bytes_q;
	assign flen = (nin > nout) ? nin : nout;
	assign pad  = flen - nin;

	// stage 0: accept, frame position, row read
	logic             in_xfer, out_xfer, rslt_go;
	logic [POS_W-1:0] pos_q, idx;
	logic [AW-1:0]    raddr;
	logic             s1_v_s1, vld_s1, last_s1;
	logic [AW-1:0]    addr_s1;
	logic [IDX_W-1:0] bidx_s1;
	logic [MAX_IN_BYTES-1:0] row_vld_q;
	logic [1:0]       cnt_q, occ;

	assign out_xfer = key_out.valid && key_out.ready;
	assign occ      = cnt_q + {1'b0, s1_v_s1};
	assign key_in.ready = (occ < 2'd2) || out_xfer;
	assign in_xfer  = key_in.valid && key_in.ready;
	assign idx      = pos_q - pad;
	assign raddr    = AW'(idx);
	assign rslt_go  = in_xfer && (op_t'(key_in.op) == OP_BYTE) && (pos_q < flen)
		&& (pos_q >= pad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			s1_v_s1 <= 1'b0;
		end else begin
			s1_v_s1 <= rslt_go;
			if (in_xfer) begin
				if (op_t'(key_in.op) == OP_START) begin
					pos_q <= '0;
				end else if (pos_q < flen) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rslt_go) begin
			addr_s1 <= raddr;
			bidx_s1 <= idx[IDX_W-1:0];
			last_s1 <= ((pos_q + 1'b1) == flen);
			vld_s1  <= row_vld_q[raddr];
		end
	end

	// raw bits ride alongside the read
	logic [7:0] raw_s1;
	always_ff @(posedge clk) begin
		if (rslt_go) begin
			raw_s1 <= key_in.rx_byte;
		end
	end

	// key table RAM
	logic [ROW_W-1:0] rdata, row, new_row;
	skdb_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_IN_BYTES)
	) u_tbl (
		.clk   (clk),
		.we    (s1_v_s1),
		.waddr (addr_s1),
		.wdata (new_row),
		.raddr (raddr),
		.rdata (rdata)
	);

	// forwarding of the row written on the edge of this read
	logic             fwd_v_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [ROW_W-1:0] fwd_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q   <= 1'b0;
			row_vld_q <= '0;
		end else begin
			fwd_v_q <= s1_v_s1;
			if (s1_v_s1) begin
				row_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_row_q  <= new_row;
	end

	always_comb begin
		if (fwd_v_q && (fwd_addr_q == addr_s1)) begin
			row = fwd_row_q;
		end else if (vld_s1) begin
			row = rdata;
		end else begin
			row = '0;
		end
	end

	// stage 1: eight debounce lanes
	always_comb begin
		logic [7:0]        held;
		logic [WORD_W-1:0] w;
		held = row[7:0];
		new_row = row;
		for (int i = 0; i < KEYS_PER_BYTE; i++) begin
			w = row[KEYS_PER_BYTE + i*WORD_W +: WORD_W];
			if (w[COUNT_W-1:0] != '0) begin
				w[COUNT_W-1:0] = w[COUNT_W-1:0] - 1'b1;
			end
			if (raw_s1[i]) begin
				if (!w[WORD_W-1]) begin
					w       = {1'b1, ticks_q};   // press registers at once
					held[i] = 1'b1;
				end
			end else begin
				if (w[WORD_W-1]) begin
					w = {1'b0, ticks_q};         // release: start countdown
				end else if (w == '0) begin
					held[i] = 1'b0;
				end
			end
			new_row[KEYS_PER_BYTE + i*WORD_W +: WORD_W] = w;
		end
		new_row[7:0] = held;
	end

	// result queue, two entries
	rslt_t rq_q [2];
	logic  wp_q, rp_q;
	rslt_t push_r;

	assign push_r = '{key_byte: new_row[7:0], byte_index: bidx_s1, last: last_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (s1_v_s1) begin
				wp_q <= ~wp_q;
			end
			if (out_xfer) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, s1_v_s1} - {1'b0, out_xfer};
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v_s1) begin
			rq_q[wp_q] <= push_r;
		end
	end

	assign key_out.valid      = (cnt_q != 2'd0);
	assign key_out.key_byte   = rq_q[rp_q].key_byte;
	assign key_out.byte_index = rq_q[rp_q].byte_index;
	assign key_out.last       = rq_q[rp_q].last;

`ifndef SYNTHESIS
	// a pending row update always finds a free queue slot
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_s1 |-> (cnt_q != 2'd2))
		else $error("result queue full with a row update in flight");

	// a start transfer rewinds the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(key_in.valid && key_in.ready && (op_t'(key_in.op) == OP_START)) |=> (pos_q == '0))
		else $error("frame position not cleared by start");

	// queue fill never exceeds its two entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !out_xfer) |=> (cnt_q == 2'd2 || !$past(s1_v_s1)))
		else $error("result queue overrun");
`endif

endmodule
`default_nettype wire

>>> sim/shift_chain_key_debounce_scanner_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_chain_key_debounce_scanner_unit_tb: self-checking scanner regression
// Streams scan frames of chain bytes through the scanner under a range of
// frame lengths and debounce loads. Each accepted byte is run through a local
// debounce model, and every key byte that comes out is checked against it.
// Source and sink stall at random, except in the full-rate phase.
// ----------------------------------------------------------------------------
module shift_chain_key_debounce_scanner_unit_tb;
	import skdb_pkg::*;

	localparam int MAX_IN        = 16;
	localparam int MAX_OUT       = 16;
	localparam int RANDOM_ITEMS  = 1900;
	localparam int SETTLE_CYCLES = 8;     // pipeline drain plus margin
	localparam int STALL_LIMIT   = 2000;  // cycles with no transfer on either side
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register here

	typedef struct {
		op_t        op;
		logic [7:0] rx;
	} chain_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	key_in_if  in_ch ();
	key_out_if out_ch ();

	shift_chain_key_debounce_scanner_unit #(
		.MAX_IN_BYTES  (MAX_IN),
		.MAX_OUT_BYTES (MAX_OUT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_in   (in_ch),
		.key_out  (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Scanner model: key table, per-key debounce words, frame position
	// and a shadow of the three registers.
	// ------------------------------------------------------------------
	logic [7:0]         held_keys   [MAX_IN]                 = '{default: 8'h00};
	logic [7:0]         settle_word [MAX_IN * KEYS_PER_BYTE] = '{default: 8'h00};
	int                 frame_pos   = 0;  // open frame right out of reset
	logic [POS_W-1:0]   cfg_in_cnt  = IN_BYTES_RST;
	logic [POS_W-1:0]   cfg_out_cnt = OUT_BYTES_RST;
	logic [COUNT_W-1:0] cfg_ticks   = TICKS_RST;

	rslt_t       expected_keys [$];  // key bytes owed by the scanner, oldest first
	chain_item_t chain_items   [$];  // transfers not yet offered
	chain_item_t next_item;

	// stimulus side: what each physical key is doing, per byte of the chain
	logic [7:0] finger_down [MAX_IN] = '{default: 8'h00};

	int src_idle_pct    = 36;
	int snk_idle_pct    = 87;
	int errors          = 0;
	int transfers_in    = 0;
	int results_checked = 0;
	int random_items    = 0;
	int settings_used   = 0;
	int quiet_cycles    = 0;

	// counts above the table size saturate
	function automatic int real_bytes();
		return (cfg_in_cnt > MAX_IN) ? MAX_IN : int'(cfg_in_cnt);
	endfunction

	function automatic int frame_len();
		int n_out;
		n_out = (cfg_out_cnt > MAX_OUT) ? MAX_OUT : int'(cfg_out_cnt);
		return (real_bytes() > n_out) ? real_bytes() : n_out;
	endfunction

	// One accepted transfer through the model. Frame starts reset the
	// position; padding and bytes past the frame end give nothing.
	task automatic scan_chain_byte(input op_t op, input logic [7:0] raw);
		int         flen, pad, idx, k;
		logic [7:0] held, word;
		rslt_t      res;
		flen = frame_len();
		pad  = flen - real_bytes();
		if (op == OP_START) begin
			frame_pos = 0;
		end else if (frame_pos < flen) begin
			frame_pos++;
			if (frame_pos > pad) begin
				idx  = frame_pos - 1 - pad;
				held = held_keys[idx];
				for (k = 0; k < KEYS_PER_BYTE; k++) begin
					word = settle_word[idx * KEYS_PER_BYTE + k];
					// countdown runs every scan, flag untouched
					if (word[COUNT_W-1:0] != '0)
						word = word - 8'd1;
					if (raw[k]) begin
						// press shows at once, unless already down
						if (!word[7]) begin
							word    = {1'b1, cfg_ticks};
							held[k] = 1'b1;
						end
					end else if (word[7]) begin
						// first released scan: arm the countdown
						word = {1'b0, cfg_ticks};
					end else if (word == 8'h00) begin
						held[k] = 1'b0;
					end
					settle_word[idx * KEYS_PER_BYTE + k] = word;
				end
				held_keys[idx]  = held;
				res.key_byte    = held;
				res.byte_index  = IDX_W'(idx);
				res.last        = (frame_pos == flen);
				expected_keys.push_back(res);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued transfers with random gaps. The model sees a
	// transfer at the edge where valid and ready meet.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.op      <= OP_START;
			in_ch.rx_byte <= 8'h00;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				scan_chain_byte(op_t'(in_ch.op), in_ch.rx_byte);
				transfers_in++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (chain_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_item      = chain_items.pop_front();
					in_ch.valid   <= 1'b1;
					in_ch.op      <= next_item.op;
					in_ch.rx_byte <= next_item.rx;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random back-pressure; each result transfer is checked
	// field by field against the oldest expectation.
	// ------------------------------------------------------------------
	rslt_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_checked++;
				if (expected_keys.size() == 0) begin
					$display("%0t: unexpected key byte: expected none, got %h index %0d last %0b",
						$time, out_ch.key_byte, out_ch.byte_index, out_ch.last);
					errors++;
				end else begin
					want = expected_keys.pop_front();
					if (out_ch.key_byte !== want.key_byte) begin
						$display("%0t: key_byte mismatch: expected %h, got %h",
							$time, want.key_byte, out_ch.key_byte);
						errors++;
					end
					if (out_ch.byte_index !== want.byte_index) begin
						$display("%0t: byte_index mismatch: expected %0d, got %0d",
							$time, want.byte_index, out_ch.byte_index);
						errors++;
					end
					if (out_ch.last !== want.last) begin
						$display("%0t: last mismatch at index %0d: expected %0b, got %0b",
							$time, want.byte_index, want.last, out_ch.last);
						errors++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// watchdog: any transfer on either side restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d key bytes still owed",
					$time, quiet_cycles, expected_keys.size());
				$display("shift_chain_key_debounce_scanner_unit regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_item(input op_t op, input logic [7:0] rx);
		chain_items.push_back('{op, rx});
	endtask

	// Sampled at the falling edge so the queues and valid have settled.
	// Padding bytes owe nothing, so allow the pipeline to empty after.
	task automatic wait_idle();
		while (chain_items.size() != 0 || in_ch.valid || expected_keys.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write; the shadow follows at once since the scanner is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] rd);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= ri;
		cfg_data <= rd;
		case (ri)
			CFG_IN_BYTES:  cfg_in_cnt  = rd[POS_W-1:0];
			CFG_OUT_BYTES: cfg_out_cnt = rd[POS_W-1:0];
			CFG_TICKS:     cfg_ticks   = rd[COUNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Key bits for one real byte: keys held for long stretches, sparse
	// contact bounce, and now and then pure noise.
	function automatic logic [7:0] chain_pattern(input int idx);
		logic [7:0] bounce;
		if ($urandom_range(99) < 8)
			finger_down[idx] ^= 8'($urandom & $urandom);
		if ($urandom_range(99) < 5)
			return 8'($urandom);
		bounce = ($urandom_range(99) < 25) ? 8'($urandom & $urandom & $urandom) : 8'h00;
		return finger_down[idx] ^ bounce;
	endfunction

	// New frame geometry and debounce load; count fields get random upper bits
	task automatic pick_settings();
		int                 r;
		logic [POS_W-1:0]   n_in, n_out;
		logic [COUNT_W-1:0] ticks;
		r = $urandom_range(99);
		if (r < 4)       n_in = 5'd0;
		else if (r < 10) n_in = 5'($urandom_range(17, 31));
		else if (r < 20) n_in = 5'd16;
		else if (r < 28) n_in = 5'd1;
		else             n_in = 5'($urandom_range(1, 16));
		r = $urandom_range(99);
		if (r < 30)      n_out = 5'd0;
		else if (r < 40) n_out = 5'd16;
		else if (r < 45) n_out = 5'($urandom_range(17, 31));
		else             n_out = 5'($urandom_range(1, 16));
		// mostly short countdowns so releases finish inside a phase
		r = $urandom_range(99);
		if (r < 5)       ticks = 7'd0;
		else if (r < 10) ticks = 7'd127;
		else if (r < 20) ticks = 7'($urandom_range(0, 127));
		else             ticks = 7'($urandom_range(1, 6));
		write_reg(CFG_IN_BYTES, {2'($urandom), n_in});
		write_reg(CFG_OUT_BYTES, {2'($urandom), n_out});
		write_reg(CFG_TICKS, ticks);
		if ($urandom_range(99) < 15)
			write_reg(CFG_UNUSED, 7'($urandom));
	endtask

	// Mostly whole frames; some cut short, some with stray bytes past the
	// end, some with a second start straight after the first.
	task automatic fill_frames(input int budget);
		int flen, pad, kind, nbytes, p, added;
		flen  = frame_len();
		pad   = flen - real_bytes();
		added = 0;
		while (added < budget) begin
			kind = $urandom_range(99);
			queue_item(OP_START, 8'($urandom));
			added++;
			if (kind >= 88 && kind < 92) begin
				queue_item(OP_START, 8'($urandom));
				added++;
			end
			nbytes = (kind < 10) ? $urandom_range(0, flen) : flen;
			for (p = 0; p < nbytes; p++) begin
				queue_item(OP_BYTE, (p < pad) ? 8'($urandom) : chain_pattern(p - pad));
				added++;
			end
			// stray bytes after the frame end are ignored and not counted
			if (kind >= 92) begin
				for (p = $urandom_range(1, 3); p > 0; p--)
					queue_item(OP_BYTE, 8'($urandom));
			end
		end
		random_items += added;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_we        = 1'b0;
		cfg_idx       = CFG_IN_BYTES;
		cfg_data      = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings (16 real bytes, ticks 10); a frame is already open
		queue_item(OP_BYTE, 8'hFF);
		queue_item(OP_BYTE, 8'h81);
		queue_item(OP_START, 8'hFF);   // byte of a start is don't-care
		queue_item(OP_BYTE, 8'h00);    // release only arms the countdown
		wait_idle();

		// 2 real bytes behind 2 padding bytes, zero ticks, dead register index
		write_reg(CFG_IN_BYTES, 7'd2);
		write_reg(CFG_OUT_BYTES, 7'd4);
		write_reg(CFG_TICKS, 7'd0);
		write_reg(CFG_UNUSED, 7'h7F);
		queue_item(OP_START, 8'h00);
		queue_item(OP_BYTE, 8'h00);
		queue_item(OP_BYTE, 8'hFF);
		queue_item(OP_BYTE, 8'h5A);
		queue_item(OP_BYTE, 8'hC3);
		queue_item(OP_BYTE, 8'hFF);    // past frame end
		repeat (2) begin
			queue_item(OP_START, 8'h00);
			repeat (4) queue_item(OP_BYTE, 8'h00);
		end
		wait_idle();

		// zero real bytes (upper data bits set): the whole frame is padding
		write_reg(CFG_IN_BYTES, 7'h60);
		write_reg(CFG_OUT_BYTES, 7'd3);
		queue_item(OP_START, 8'h00);
		repeat (3) queue_item(OP_BYTE, 8'hFF);
		wait_idle();

		// counts past the table size saturate; longest countdown
		write_reg(CFG_IN_BYTES, 7'd31);
		write_reg(CFG_OUT_BYTES, 7'd31);
		write_reg(CFG_TICKS, 7'd127);
		queue_item(OP_START, 8'h00);
		queue_item(OP_BYTE, 8'hFF);
		queue_item(OP_BYTE, 8'h01);
		queue_item(OP_BYTE, 8'h00);
		wait_idle();

		// random phases: slow sink, then slow source, then full rate
		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 3) begin
				src_idle_pct = 36;
				snk_idle_pct = 87;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct = 87;
				snk_idle_pct = 36;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			pick_settings();
			settings_used++;
			fill_frames($urandom_range(120, 260));
			wait_idle();
		end

		$display("covered %0d chain transfers (%0d random) over %0d random register settings",
			transfers_in, random_items, settings_used);
		$display("checked %0d debounced key bytes, %0d mismatches", results_checked, errors);
		if (errors == 0)
			$display("shift_chain_key_debounce_scanner_unit regression: pass");
		else
			$display("shift_chain_key_debounce_scanner_unit regression: fail");
		$finish;
	end

endmodule

>>> sim.f
sv/skdb_pkg.sv
sv/skdb_if.sv
sv/skdb_ram.sv
sv/shift_chain_key_debounce_scanner_unit.sv
sim/shift_chain_key_debounce_scanner_unit_tb.sv
